/* hw/rtl/sas_pkg.sv */
package sas_pkg;

   localparam int WINDOW_DEF   = 64;
   localparam int ACK_SPAN_DEF = 64;

   localparam int REQ_TDATA_W = 208;
   localparam int RSP_TDATA_W = 336;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [10:0] MSS_RST    = 11'd1360;
   localparam logic [6:0]  HDR_RST    = 7'd49;
   localparam logic [8:0]  ALPHA_RST  = 9'd32;
   localparam logic [8:0]  GAIN_RST   = 9'd64;
   localparam logic [31:0] WINDOW_RST = 32'd4 * {21'd0, MSS_RST};

   localparam logic [CSR_IDX_W-1:0] CSR_MSS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HDR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd3;

   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_XMIT = 2'd1;
   localparam logic [1:0] REQ_ACK  = 2'd2;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_EXEC = 11'b000_0000_0010,
      S_RD   = 11'b000_0000_0100,
      S_CHK  = 11'b000_0000_1000,
      S_M1   = 11'b000_0001_0000,
      S_A1   = 11'b000_0010_0000,
      S_DIF  = 11'b000_0100_0000,
      S_M2   = 11'b000_1000_0000,
      S_A2   = 11'b001_0000_0000,
      S_RTO  = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic read;
      logic keep;
      logic next;
      logic mul1;
      logic add1;
      logic diff;
      logic mul2;
      logic add2;
      logic rto;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_ack;
      logic fill_zero;
      logic acked;
      logic last;
      logic rsp_busy;
   } sts_type;

endpackage

/* hw/rtl/sas_ctrl.sv */
module sas_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sas_pkg::sts_type sts,
   output sas_pkg::cmd_type cmd
);
   import sas_pkg::*;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.is_ack && !sts.fill_zero) ? S_RD : S_DONE;
         end
         S_RD: begin
            cmd.read = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.acked) begin
               state_in = S_M1;
            end else begin
               cmd.keep = 1'b1;
               cmd.next = 1'b1;
               state_in = sts.last ? S_DONE : S_RD;
            end
         end
         S_M1: begin
            cmd.mul1 = 1'b1;
            state_in = S_A1;
         end
         S_A1: begin
            cmd.add1 = 1'b1;
            state_in = S_DIF;
         end
         S_DIF: begin
            cmd.diff = 1'b1;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.mul2 = 1'b1;
            state_in = S_A2;
         end
         S_A2: begin
            cmd.add2 = 1'b1;
            state_in = S_RTO;
         end
         S_RTO: begin
            cmd.rto  = 1'b1;
            cmd.next = 1'b1;
            state_in = sts.last ? S_DONE : S_RD;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/sas_datapath.sv */
module sas_datapath #(
   parameter int WINDOW   = sas_pkg::WINDOW_DEF,
   parameter int ACK_SPAN = sas_pkg::ACK_SPAN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sas_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sas_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [sas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sas_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  sas_pkg::cmd_type                  cmd,
   output sas_pkg::sts_type                  sts
);
   import sas_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
   localparam logic [63:0] SPAN = 64'(ACK_SPAN);

   // config
   logic [10:0] mss_ff;
   logic [6:0]  hdr_ff;
   logic [8:0]  alpha_ff, gain_ff;

   // latched request
   logic [1:0]  type_ff;
   logic [10:0] pay_ff;
   logic [63:0] now_ff, cum_ff, bits_ff;

   // table
   logic [63:0] seq_mem  [WINDOW];
   logic [10:0] size_mem [WINDOW];
   logic [63:0] time_mem [WINDOW];
   logic [63:0] rd_seq_ff, rd_time_ff;
   logic [10:0] rd_size_ff;
   logic [CNT_W-1:0] fill_ff, rd_idx_ff, wr_idx_ff;

   // state
   logic [63:0] next_seq_ff, srtt_ff, var_ff, rto_ff;
   logic [31:0] flight_ff, window_ff;
   logic [63:0] sample_ff, diff_ff;
   logic [10:0] rel_size_ff;
   logic [63:0] p0_ff, p1_ff;
   logic [17:0] lo_ff;

   // per-request result fields
   logic [63:0] seq_out_ff;
   logic        full_ff;
   logic [6:0]  released_ff;

   logic                     rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;

   function automatic logic [8:0] clamp_w(input logic [8:0] w);
      clamp_w = (w > 9'd256) ? 9'd256 : w;
   endfunction

   function automatic logic [10:0] pkt_size(input logic [6:0] h, input logic [10:0] p);
      logic [11:0] s;
      s = {5'd0, h} + {1'b0, p};
      pkt_size = s[11] ? 11'h7FF : s[10:0];
   endfunction

   // ack test for the entry just read
   logic [63:0] off;
   logic        acked;
   assign off   = rd_seq_ff - cum_ff - 64'd1;
   assign acked = (rd_seq_ff <= cum_ff) || ((off < SPAN) && bits_ff[off[5:0]]);

   assign sts.is_ack    = (type_ff == REQ_ACK);
   assign sts.fill_zero = (fill_ff == '0);
   assign sts.acked     = acked;
   assign sts.last      = (rd_idx_ff == fill_ff - CNT_W'(1));
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_tready;

   // shared blend multiplier: srtt with sample, or var with diff
   logic [63:0] mx, my;
   logic [8:0]  w1, w0;
   logic [64:0] m0, m1;
   logic [17:0] l0, l1;
   assign mx = cmd.mul2 ? var_ff : srtt_ff;
   assign my = cmd.mul2 ? diff_ff : sample_ff;
   assign w1 = clamp_w(cmd.mul2 ? gain_ff : alpha_ff);
   assign w0 = 9'd256 - w1;
   assign m0 = {56'd0, w0} * {9'd0, mx[63:8]};
   assign m1 = {56'd0, w1} * {9'd0, my[63:8]};
   assign l0 = {9'd0, w0} * {10'd0, mx[7:0]};
   assign l1 = {9'd0, w1} * {10'd0, my[7:0]};

   logic [63:0] blend_sum;
   assign blend_sum = p0_ff + p1_ff + {56'd0, lo_ff[15:8]};

   logic [32:0] fl_add, win_chk, win_add;
   assign fl_add  = {1'b0, flight_ff} + {22'd0, pkt_size(hdr_ff, pay_ff)};
   assign win_chk = {1'b0, flight_ff} + {22'd0, mss_ff};
   assign win_add = {1'b0, window_ff} + {22'd0, mss_ff};

   logic [63:0] four;
   logic [64:0] rto_sum;
   assign four    = (var_ff[63:62] != 2'b00) ? '1 : {var_ff[61:0], 2'b00};
   assign rto_sum = {1'b0, srtt_ff} + {1'b0, four};

   // table write port, plus the registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && type_ff == REQ_SEND && fill_ff < WIN_CNT) begin
         seq_mem[fill_ff[IDX_W-1:0]]  <= next_seq_ff;
         size_mem[fill_ff[IDX_W-1:0]] <= pkt_size(hdr_ff, pay_ff);
         time_mem[fill_ff[IDX_W-1:0]] <= now_ff;
      end else if (cmd.keep) begin
         seq_mem[wr_idx_ff[IDX_W-1:0]]  <= rd_seq_ff;
         size_mem[wr_idx_ff[IDX_W-1:0]] <= rd_size_ff;
         time_mem[wr_idx_ff[IDX_W-1:0]] <= rd_time_ff;
      end
      if (cmd.read) begin
         rd_seq_ff  <= seq_mem[rd_idx_ff[IDX_W-1:0]];
         rd_size_ff <= size_mem[rd_idx_ff[IDX_W-1:0]];
         rd_time_ff <= time_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // payload-only registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_tuser;
         pay_ff  <= req_tdata[10:0];
         now_ff  <= req_tdata[74:11];
         cum_ff  <= req_tdata[138:75];
         bits_ff <= req_tdata[202:139];
      end
      if (cmd.read) begin
         // sample computed next cycle from the fresh read data
      end
      if (acked) begin
         sample_ff   <= (now_ff >= rd_time_ff) ? now_ff - rd_time_ff : 64'd0;
         rel_size_ff <= rd_size_ff;
      end
      if (cmd.mul1 || cmd.mul2) begin
         p0_ff <= m0[63:0];
         p1_ff <= m1[63:0];
         lo_ff <= l0 + l1;
      end
      if (cmd.diff) begin
         diff_ff <= (sample_ff >= srtt_ff) ? sample_ff - srtt_ff : srtt_ff - sample_ff;
      end
      if (cmd.finish) begin
         rsp_data_ff <= {7'd0, flight_ff < window_ff, rto_ff, var_ff, srtt_ff,
                         window_ff, flight_ff, released_ff, full_ff, seq_out_ff};
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff       <= MSS_RST;
         hdr_ff       <= HDR_RST;
         alpha_ff     <= ALPHA_RST;
         gain_ff      <= GAIN_RST;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         next_seq_ff  <= '0;
         flight_ff    <= '0;
         window_ff    <= WINDOW_RST;
         srtt_ff      <= '0;
         var_ff       <= '0;
         rto_ff       <= '0;
         seq_out_ff   <= '0;
         full_ff      <= 1'b0;
         released_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MSS:   mss_ff   <= csr_wr_data;
               CSR_HDR:   hdr_ff   <= csr_wr_data[6:0];
               CSR_ALPHA: alpha_ff <= csr_wr_data[8:0];
               CSR_GAIN:  gain_ff  <= csr_wr_data[8:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            seq_out_ff  <= '0;
            full_ff     <= 1'b0;
            released_ff <= '0;
         end
         if (cmd.exec) begin
            rd_idx_ff <= '0;
            wr_idx_ff <= '0;
            if (type_ff == REQ_SEND) begin
               if (fill_ff >= WIN_CNT) begin
                  full_ff <= 1'b1;
               end else begin
                  fill_ff     <= fill_ff + CNT_W'(1);
                  seq_out_ff  <= next_seq_ff;
                  next_seq_ff <= next_seq_ff + 64'd1;
               end
            end else if (type_ff == REQ_XMIT) begin
               flight_ff <= fl_add[32] ? '1 : fl_add[31:0];
            end
         end
         if (cmd.keep) begin
            wr_idx_ff <= wr_idx_ff + CNT_W'(1);
         end
         if (cmd.next) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
         if (cmd.mul1) begin
            flight_ff <= (flight_ff >= {21'd0, rel_size_ff}) ?
                         flight_ff - {21'd0, rel_size_ff} : 32'd0;
            if (released_ff != 7'h7F) begin
               released_ff <= released_ff + 7'd1;
            end
         end
         if (cmd.add1) begin
            srtt_ff <= blend_sum;
            if (win_chk <= {1'b0, window_ff}) begin
               window_ff <= win_add[32] ? '1 : win_add[31:0];
            end
         end
         if (cmd.add2) begin
            var_ff <= blend_sum;
         end
         if (cmd.rto) begin
            rto_ff <= rto_sum[64] ? '1 : rto_sum[63:0];
         end
         if (cmd.finish && type_ff == REQ_ACK) begin
            fill_ff <= wr_idx_ff;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/selective_ack_sender_scoreboard_top.sv */
// Sender scoreboard: send requests get sequence numbers and a table slot, transmit
// requests add to the in-flight bytes, ack requests walk the table oldest first and
// release acked entries while updating window, smoothed RTT, variation and RTO.
// One request is handled at a time; the result sits in an output register so the
// next request is taken while it waits. An ack takes longer the more table entries
// it walks and releases, set by the one-entry-per-read table walk and the shared
// blend multiplier that runs twice per release.
module selective_ack_sender_scoreboard_top #(
   parameter int WINDOW   = sas_pkg::WINDOW_DEF,
   parameter int ACK_SPAN = sas_pkg::ACK_SPAN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // payload_len[10:0], now_ns[74:11], cumulative_ack[138:75], ack_bits[202:139]
   input  logic [sas_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // seq_assigned[63:0], table_full[64], released_count[71:65],
   // in_flight_bytes[103:72], cong_window[135:104], smoothed_rtt[199:136],
   // rtt_var[263:200], retrans_timeout[327:264], send_allowed[328]
   output logic [sas_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [sas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sas_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sas_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sas_datapath #(
      .WINDOW   (WINDOW),
      .ACK_SPAN (ACK_SPAN)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

/* hw/rtl/sas_checker.sv */
module sas_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sas_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sas_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   a_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[328] == (rsp_tdata[103:72] < rsp_tdata[135:104]))
      else $error("send_allowed inconsistent with window");

   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[63:0] == 64'd0 && rsp_tdata[71:65] == 7'd0)
      else $error("refused send reports sequence or releases");

endmodule

bind selective_ack_sender_scoreboard_top sas_checker u_sas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
